// ===== sv/fla_pkg.sv =====
// ----------------------------------------------------------------------------
// fla_pkg: shared types and constants
// Operation and status codes, widths, and the controller/datapath command
// and status groups of the free-list block allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);  // slot index width
  localparam int LINK_W    = SLOT_W + 1;         // link, head, count, capacity
  localparam int CAP_W     = 11;                 // capacity register width
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 3;
  localparam int MEM_W     = LINK_W + 1;         // {used, link}

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_CLEAR = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_HEAD_USED   = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_RANGE       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,   // wipe after reset
    S_IDLE,   // take a word
    S_EXEC,   // link word read back, act on it
    S_CLR,    // wipe for a clear
    S_FIN     // deliver the clear result
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load_out;
    logic wipe_start;
    logic wipe_step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic wipe_last;
  } dp_sts_t;

  // Bound the latched capacity to 1..MAX_SLOTS.
  function automatic logic [LINK_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [LINK_W-1:0] r;
    if (v == '0) begin
      r = LINK_W'(1);
    end else if (int'(v) > MAX_SLOTS) begin
      r = LINK_W'(MAX_SLOTS);
    end else begin
      r = LINK_W'(v);
    end
    return r;
  endfunction

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(1024);
  localparam logic [LINK_W-1:0] END_MARK   = LINK_W'(MAX_SLOTS);

endpackage

// ===== sv/fla_ifs.sv =====
// ----------------------------------------------------------------------------
// fla_ifs: channel interfaces
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface fla_in_if;
  logic                      valid;
  logic                      ready;
  logic [fla_pkg::FUNC_W-1:0] func;
  logic [fla_pkg::SLOT_W-1:0] slot_index;

  modport source (output valid, output func, output slot_index, input ready);
  modport sink   (input valid, input func, input slot_index, output ready);
endinterface

interface fla_out_if;
  logic                       valid;
  logic                       ready;
  logic [fla_pkg::STAT_W-1:0] status;
  logic [fla_pkg::SLOT_W-1:0] granted_slot;
  logic [fla_pkg::LINK_W-1:0] slots_in_use;

  modport source (output valid, output status, output granted_slot,
                  output slots_in_use, input ready);
  modport sink   (input valid, input status, input granted_slot,
                  input slots_in_use, output ready);
endinterface

// ===== sv/fla_ctrl.sv =====
// ----------------------------------------------------------------------------
// fla_ctrl: allocator controller
// Sequences wipe passes, link read and update, and the result register.
// ----------------------------------------------------------------------------
module fla_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  fla_pkg::dp_sts_t sts,
  output fla_pkg::dp_cmd_t cmd
);

  fla_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fla_pkg::S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      fla_pkg::S_INIT: begin
        cmd.wipe_step = 1'b1;
        if (sts.wipe_last) begin
          state_nxt = fla_pkg::S_IDLE;
        end
      end
      fla_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = fla_pkg::S_EXEC;
        end
      end
      fla_pkg::S_EXEC: begin
        if (sts.is_clear) begin
          cmd.wipe_start = 1'b1;
          state_nxt      = fla_pkg::S_CLR;
        end else if (out_free) begin
          cmd.exec     = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = fla_pkg::S_IDLE;
        end
      end
      fla_pkg::S_CLR: begin
        cmd.wipe_step = 1'b1;
        if (sts.wipe_last) begin
          state_nxt = fla_pkg::S_FIN;
        end
      end
      fla_pkg::S_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = fla_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fla_pkg::S_INIT;
      end
    endcase
  end

  // hold the result word until taken; a new load replaces a taken one
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

// ===== sv/fla_datapath.sv =====
// ----------------------------------------------------------------------------
// fla_datapath: allocator datapath
// Link memory with used marks, free-list head, use count, capacity
// registers, wipe counter and the result register.
// ----------------------------------------------------------------------------
module fla_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fla_pkg::dp_cmd_t           cmd,
  output fla_pkg::dp_sts_t           sts,
  input  logic [fla_pkg::FUNC_W-1:0] in_func,
  input  logic [fla_pkg::SLOT_W-1:0] in_slot_index,
  input  logic                       cfg_we,
  input  logic [fla_pkg::CAP_W-1:0]  cfg_wdata,
  output logic [fla_pkg::STAT_W-1:0] out_status,
  output logic [fla_pkg::SLOT_W-1:0] out_granted_slot,
  output logic [fla_pkg::LINK_W-1:0] out_slots_in_use
);

  localparam int SW = fla_pkg::SLOT_W;
  localparam int LW = fla_pkg::LINK_W;

  // each entry: {used mark, next link}
  logic [fla_pkg::MEM_W-1:0] mem [fla_pkg::MAX_SLOTS];

  logic [fla_pkg::CAP_W-1:0] pool_cap_r;
  logic [LW-1:0]             active_cap_r;
  logic [LW-1:0]             head_r, head_nxt;
  logic [LW-1:0]             count_r, count_nxt;
  logic [SW-1:0]             wipe_cnt_r;
  fla_pkg::func_t            func_r;
  logic [SW-1:0]             idx_r;
  logic [fla_pkg::MEM_W-1:0] rd_q;

  fla_pkg::status_t          out_status_r;
  logic [SW-1:0]             out_granted_r;
  logic [LW-1:0]             out_count_r;

  logic [SW-1:0]             rd_addr;
  logic                      mem_we;
  logic [SW-1:0]             mem_wa;
  logic [fla_pkg::MEM_W-1:0] mem_wd;
  logic                      rd_used;
  logic [LW-1:0]             rd_link;
  logic [LW-1:0]             wipe_link;
  fla_pkg::status_t          res_status;
  logic [SW-1:0]             res_granted;

  assign rd_used = rd_q[LW];
  assign rd_link = rd_q[LW-1:0];

  assign sts.is_clear  = (func_r == fla_pkg::FN_CLEAR);
  assign sts.wipe_last = (wipe_cnt_r == SW'(fla_pkg::MAX_SLOTS - 1));

  // rebuilt list: i -> i+1, the last active slot ends the list
  assign wipe_link = ({1'b0, wipe_cnt_r} == active_cap_r - LW'(1)) ?
                     fla_pkg::END_MARK : ({1'b0, wipe_cnt_r} + LW'(1));

  assign rd_addr = (fla_pkg::func_t'(in_func) == fla_pkg::FN_ALLOC) ?
                   head_r[SW-1:0] : in_slot_index;

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    res_status  = fla_pkg::ST_OK;
    res_granted = '0;
    mem_we      = 1'b0;
    mem_wa      = wipe_cnt_r;
    mem_wd      = {1'b0, wipe_link};
    if (cmd.wipe_step) begin
      mem_we = 1'b1;
    end
    if (cmd.wipe_start) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.exec) begin
      unique case (func_r)
        fla_pkg::FN_ALLOC: begin
          if (head_r >= active_cap_r) begin
            res_status = fla_pkg::ST_EMPTY;
          end else if (rd_used) begin
            res_status = fla_pkg::ST_HEAD_USED;
          end else begin
            mem_we      = 1'b1;
            mem_wa      = head_r[SW-1:0];
            mem_wd      = {1'b1, rd_link};
            head_nxt    = rd_link;
            count_nxt   = count_r + LW'(1);
            res_granted = head_r[SW-1:0];
          end
        end
        fla_pkg::FN_FREE: begin
          if ({1'b0, idx_r} >= active_cap_r) begin
            res_status = fla_pkg::ST_RANGE;
          end else if (!rd_used) begin
            res_status = fla_pkg::ST_DOUBLE_FREE;
          end else begin
            mem_we   = 1'b1;
            mem_wa   = idx_r;
            mem_wd   = {1'b0, head_r};
            head_nxt = {1'b0, idx_r};
            if (count_r != '0) begin
              count_nxt = count_r - LW'(1);
            end
          end
        end
        default: begin
          // unused code: report the count, change nothing
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.accept) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_cap_r   <= fla_pkg::CAP_RESET;
      active_cap_r <= fla_pkg::clamp_cap(fla_pkg::CAP_RESET);
      head_r       <= '0;
      count_r      <= '0;
      wipe_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        pool_cap_r <= cfg_wdata;
      end
      if (cmd.wipe_start) begin
        active_cap_r <= fla_pkg::clamp_cap(pool_cap_r);
        wipe_cnt_r   <= '0;
      end else if (cmd.wipe_step) begin
        wipe_cnt_r <= wipe_cnt_r + SW'(1);
      end
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= fla_pkg::func_t'(in_func);
      idx_r  <= in_slot_index;
    end
    if (cmd.load_out) begin
      out_status_r  <= res_status;
      out_granted_r <= res_granted;
      out_count_r   <= count_nxt;
    end
  end

  assign out_status       = out_status_r;
  assign out_granted_slot = out_granted_r;
  assign out_slots_in_use = out_count_r;

endmodule

// ===== sv/free_list_block_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_block_allocator: fixed-size block free-list allocator
// Hands out slot indices from a linked free list; frees push slots back,
// a clear rebuilds the list for the latched capacity.
// ----------------------------------------------------------------------------
//   port     | dir | handshake     | word
//   ---------+-----+---------------+------------------------------------------
//   in_ch    | in  | valid/ready   | func, slot_index
//   out_ch   | out | valid/ready   | status, granted_slot, slots_in_use
//   cfg_*    | in  | cfg_we strobe | cfg_wdata = pool_capacity
//
// Allocate and free read the link memory entry in S_IDLE, then check it and
// write it back in S_EXEC. One word is in flight at a time.
// Clear rewrites the link memory in S_CLR, one entry per cycle, and then
// delivers its result from S_FIN. Reset runs the same pass with in_ch not ready.
// A result waits in the output register; the next word is taken meanwhile,
// and its result stalls only until the register is taken.
// ----------------------------------------------------------------------------
module free_list_block_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  fla_in_if.sink                    in_ch,
  fla_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [fla_pkg::CAP_W-1:0] cfg_wdata
);

  fla_pkg::dp_cmd_t cmd;
  fla_pkg::dp_sts_t sts;

  fla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fla_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_ch.func),
    .in_slot_index    (in_ch.slot_index),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_status       (out_ch.status),
    .out_granted_slot (out_ch.granted_slot),
    .out_slots_in_use (out_ch.slots_in_use)
  );

endmodule

// ===== sv/fla_checker.sv =====
// ----------------------------------------------------------------------------
// fla_checker: port-level checks for the allocator
// Watches both channels of the top level over time.
// ----------------------------------------------------------------------------
module fla_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [fla_pkg::STAT_W-1:0] status,
  input logic [fla_pkg::SLOT_W-1:0] granted_slot,
  input logic [fla_pkg::LINK_W-1:0] slots_in_use
);

  // a pending result word stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // one word in flight: no take in the cycle after a take
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken right after the first");

  // only a successful allocate grants a slot
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != fla_pkg::ST_OK) |-> granted_slot == '0)
    else $error("slot granted with an error status");

  // the use count never passes the pool size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(slots_in_use) <= fla_pkg::MAX_SLOTS)
    else $error("slots in use above pool size");

endmodule

bind free_list_block_allocator fla_checker u_fla_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .granted_slot (out_ch.granted_slot),
  .slots_in_use (out_ch.slots_in_use)
);
